// ----- rtl/elic_pkg.sv -----
// Shared types and codes for the edge/level interrupt controller.
// No dependencies; every other file refers to this package by scoped names.
package elic_pkg;

    localparam int NUM_LINES_DEF = 32;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = 5;
    localparam int CMD_W         = 2;
    localparam int SEL_W         = 3;
    localparam int IN_DATA_W     = 2 * WORD_W;
    localparam int IN_USER_W     = CMD_W + SEL_W;
    localparam int OUT_FIELDS_W  = WORD_W + 1 + IDX_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // register select codes
    localparam logic [SEL_W-1:0] SEL_STATUS   = 3'd0;
    localparam logic [SEL_W-1:0] SEL_ENABLE   = 3'd1;
    localparam logic [SEL_W-1:0] SEL_SET      = 3'd2;
    localparam logic [SEL_W-1:0] SEL_CLEAR    = 3'd3;
    localparam logic [SEL_W-1:0] SEL_POLARITY = 3'd4;
    localparam logic [SEL_W-1:0] SEL_EDGE     = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SEL_W-1:0]  reg_select;
        logic [WORD_W-1:0] write_data;
        logic [WORD_W-1:0] line_levels;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq_any;
        logic [IDX_W-1:0]  first_pending;
    } result_t;

endpackage

// ----- rtl/elic_prio.sv -----
// Lowest-set-bit encoder for the pending word.
// Depends on elic_pkg for the index width.
module elic_prio #(
    parameter int NUM_LINES = elic_pkg::NUM_LINES_DEF
) (
    input  logic [NUM_LINES-1:0]        pending,
    output logic                        any,
    output logic [elic_pkg::IDX_W-1:0]  index
);

    logic [NUM_LINES-1:0] lowest;

    // isolate lowest set bit, then OR-encode its position
    assign lowest = pending & (~pending + NUM_LINES'(1));
    assign any    = |pending;

    always_comb begin
        index = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            if (lowest[i]) begin
                index = index | elic_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// ----- rtl/elic_regs.sv -----
// Per-line state registers, command decode and status/pending word.
// Depends on elic_pkg for codes and the item struct.
module elic_regs #(
    parameter int NUM_LINES = elic_pkg::NUM_LINES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  elic_pkg::item_t               item,
    output logic [elic_pkg::WORD_W-1:0]   read_data,
    output logic [NUM_LINES-1:0]          pending
);

    logic [NUM_LINES-1:0] enable_reg,   enable_next;
    logic [NUM_LINES-1:0] polarity_reg, polarity_next;
    logic [NUM_LINES-1:0] edge_reg,     edge_next;
    logic [NUM_LINES-1:0] latch_reg,    latch_next;
    logic [NUM_LINES-1:0] levels_reg,   levels_next;

    logic [NUM_LINES-1:0] data, levels, hit, status;
    logic [NUM_LINES-1:0] rd;

    assign data   = item.write_data[NUM_LINES-1:0];
    assign levels = item.line_levels[NUM_LINES-1:0];

    // edge hit: rising on active-high lines, falling on active-low lines
    assign hit = (levels & ~levels_reg & polarity_reg)
               | (~levels & levels_reg & ~polarity_reg);

    always_comb begin
        enable_next   = enable_reg;
        polarity_next = polarity_reg;
        edge_next     = edge_reg;
        latch_next    = latch_reg;
        levels_next   = levels_reg;
        case (item.command)
            elic_pkg::CMD_TICK: begin
                latch_next  = latch_reg | (hit & edge_reg);
                levels_next = levels;
            end
            elic_pkg::CMD_WRITE: begin
                case (item.reg_select)
                    elic_pkg::SEL_ENABLE:   enable_next   = data;
                    elic_pkg::SEL_CLEAR:    latch_next    = latch_reg & ~data;
                    elic_pkg::SEL_POLARITY: polarity_next = data;
                    elic_pkg::SEL_EDGE:     edge_next     = data;
                    default: ;   // status, set and unused selects ignore writes
                endcase
            end
            default: ;           // reads and unused command change nothing
        endcase
    end

    // status after the item: latched edge lines, or level lines at polarity
    assign status  = (latch_next & edge_next)
                   | (~(levels_next ^ polarity_next) & ~edge_next);
    assign pending = status & enable_next;

    always_comb begin
        rd = '0;
        if (item.command == elic_pkg::CMD_READ) begin
            case (item.reg_select)
                elic_pkg::SEL_STATUS:   rd = status;
                elic_pkg::SEL_ENABLE:   rd = enable_reg;
                elic_pkg::SEL_POLARITY: rd = polarity_reg;
                elic_pkg::SEL_EDGE:     rd = edge_reg;
                default:                rd = '0;
            endcase
        end
    end

    assign read_data = elic_pkg::WORD_W'(rd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= '0;
            polarity_reg <= '1;
            edge_reg     <= '0;
            latch_reg    <= '0;
            levels_reg   <= '0;
        end else if (fire) begin
            enable_reg   <= enable_next;
            polarity_reg <= polarity_next;
            edge_reg     <= edge_next;
            latch_reg    <= latch_next;
            levels_reg   <= levels_next;
        end
    end

endmodule

// ----- rtl/edge_level_interrupt_controller.sv -----
// Edge/level interrupt controller, one bank of up to NUM_LINES lines.
// An accepted input beat passes through the input register, then the state
// update and the result register, before its result beat is valid.
// Throughput: one beat per cycle while the sink accepts results; the state update sets the rate.
// Reset (aresetn low, synchronous): all lines masked, active high, level mode,
// edge latches and sampled levels cleared, both pipeline stages emptied.
module edge_level_interrupt_controller #(
    parameter int NUM_LINES = elic_pkg::NUM_LINES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] write_data, [63:32] line_levels
    input  logic [elic_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] command, [4:2] reg_select
    input  logic [elic_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] read_data, [32] irq_any, [37:33] first_pending, [39:38] zero
    output logic [elic_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // Stage 1: input register holding one accepted beat.
    logic            in_valid_reg, in_valid_next;
    elic_pkg::item_t in_item_reg;

    // Stage 2: result register.
    logic                              out_valid_reg, out_valid_next;
    logic [elic_pkg::OUT_DATA_W-1:0]   out_data_reg;

    logic                              s_fire;
    logic                              advance;
    logic [elic_pkg::WORD_W-1:0]       read_data;
    logic [NUM_LINES-1:0]              pending;
    elic_pkg::result_t                 result;

    // The stage-1 beat moves on when the result register is empty or draining,
    // so a new beat enters every cycle while the sink keeps up.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // State is committed exactly when the beat leaves stage 1.
    elic_regs #(
        .NUM_LINES (NUM_LINES)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (in_item_reg),
        .read_data (read_data),
        .pending   (pending)
    );

    elic_prio #(
        .NUM_LINES (NUM_LINES)
    ) u_prio (
        .pending (pending),
        .any     (result.irq_any),
        .index   (result.first_pending)
    );

    assign result.read_data = read_data;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.command     <= s_axis_tuser[elic_pkg::CMD_W-1:0];
            in_item_reg.reg_select  <= s_axis_tuser[elic_pkg::IN_USER_W-1:elic_pkg::CMD_W];
            in_item_reg.write_data  <= s_axis_tdata[elic_pkg::WORD_W-1:0];
            in_item_reg.line_levels <= s_axis_tdata[elic_pkg::IN_DATA_W-1:elic_pkg::WORD_W];
        end
        if (advance) begin
            out_data_reg <= elic_pkg::OUT_DATA_W'({result.first_pending,
                                                   result.irq_any,
                                                   result.read_data});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
